// File: rtl/bitpacked_equality_scan_count_macros.svh
// Assertion macros for the equality scan block
`ifndef BITPACKED_EQUALITY_SCAN_COUNT_MACROS_SVH
`define BITPACKED_EQUALITY_SCAN_COUNT_MACROS_SVH

// same-cycle implication
`define BESC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/besc_pkg.sv
// ----------------------------------------------------------------------------
// besc_pkg
// Shared constants and types for the bit-packed equality scan.
// ----------------------------------------------------------------------------
package besc_pkg;

    localparam int LANES      = 32;
    localparam int LANE_BITS  = $clog2(LANES);
    localparam int COUNT_BITS = 48;
    localparam int WORD_BITS  = 32;
    localparam int ACC_BITS   = 2 * WORD_BITS - 1;
    localparam int AVAIL_BITS = $clog2(ACC_BITS + 1);

    localparam logic [1:0] REG_BIT_WIDTH   = 2'd0;
    localparam logic [1:0] REG_MATCH_VALUE = 2'd1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic emit;
    } besc_cmd_t;

    typedef struct packed {
        logic more;
        logic last;
    } besc_status_t;

endpackage

// File: rtl/besc_ctrl.sv
// ----------------------------------------------------------------------------
// besc_ctrl
// Sequencer: accepts a word, steps the extractor, emits the count.
// ----------------------------------------------------------------------------
module besc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  besc_pkg::besc_status_t status,
    output besc_pkg::besc_cmd_t    cmd
);
    import besc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.more)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = status.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a pending config write goes ahead of a word
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/besc_datapath.sv
// ----------------------------------------------------------------------------
// besc_datapath
// Lane leftover store, value extractor, comparator and saturating count.
// ----------------------------------------------------------------------------
module besc_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  besc_pkg::besc_cmd_t              cmd,
    output besc_pkg::besc_status_t           status,
    input  logic                             cfg_write,
    input  logic [1:0]                       cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic [31:0]                      packed_word,
    input  logic                             last_word,
    output logic [besc_pkg::COUNT_BITS-1:0]  match_count
);
    import besc_pkg::*;

    logic [5:0]            bit_width_reg;
    logic [31:0]           match_value_reg;
    logic [30:0]           leftover_mem [LANES];
    logic [LANE_BITS-1:0]  lane_reg;
    logic [4:0]            row_reg;
    logic [4:0]            len_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] out_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [AVAIL_BITS-1:0] avail_reg;
    logic                  last_reg;

    logic [5:0]            width;
    logic [31:0]           val_mask;
    logic [31:0]           len_mask;
    logic [ACC_BITS-1:0]   acc_load;
    logic                  hit;
    logic [5:0]            row_inc;

    assign width    = (bit_width_reg > 6'd32) ? 6'd32 : bit_width_reg;
    assign val_mask = (width >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    assign len_mask = (32'd1 << len_reg) - 32'd1;
    assign acc_load = ACC_BITS'({1'b0, leftover_mem[lane_reg]} & len_mask)
                    | (ACC_BITS'(packed_word) << len_reg);
    assign hit      = ((acc_reg[31:0] & val_mask) == match_value_reg);
    assign row_inc  = 6'(row_reg) + 6'd1;

    assign status.more = (width != 6'd0) && (avail_reg >= width);
    assign status.last = last_reg;
    assign match_count = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg   <= acc_load;
            avail_reg <= AVAIL_BITS'(len_reg) + AVAIL_BITS'(WORD_BITS);
            last_reg  <= last_word;
        end
        else if (cmd.step)
        begin
            acc_reg   <= acc_reg >> width;
            avail_reg <= avail_reg - width;
        end
        if (cmd.finish && width != 6'd0)
        begin
            leftover_mem[lane_reg] <= acc_reg[30:0];
        end
        if (cmd.emit)
        begin
            out_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_width_reg   <= 6'd32;
            match_value_reg <= '0;
            lane_reg        <= '0;
            row_reg         <= '0;
            len_reg         <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_BIT_WIDTH)
            begin
                bit_width_reg <= cfg_data[5:0];
                lane_reg      <= '0;
                row_reg       <= '0;
                len_reg       <= '0;
            end
            if (cfg_write && cfg_index == REG_MATCH_VALUE)
            begin
                match_value_reg <= cfg_data;
            end
            if (cmd.step && hit && count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.finish && width != 6'd0)
            begin
                lane_reg <= lane_reg + LANE_BITS'(1);
                if (lane_reg == LANE_BITS'(LANES - 1))
                begin
                    if (row_inc >= width)
                    begin
                        row_reg <= '0;
                        len_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_inc[4:0];
                        len_reg <= avail_reg[4:0];
                    end
                end
            end
            if (cmd.emit)
            begin
                count_reg <= '0;
                lane_reg  <= '0;
                row_reg   <= '0;
                len_reg   <= '0;
            end
        end
    end

endmodule

// File: rtl/bitpacked_equality_scan_count.sv
// ----------------------------------------------------------------------------
// bitpacked_equality_scan_count
// Counts values equal to a target in a 32-lane interleaved bit-packed column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one packed word per handshake with
//   last_word marking the final word of a column. Output channel
//   (out_valid/out_ready) delivers one saturating match_count per last word.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   bit_width (index 0) and match_value (index 1) while idle; a pending
//   config write holds off the input. Writing bit_width restarts alignment.
//   Each word is accepted, then the extractor tests one value per cycle while
//   a full value remains, then the leftover bits are stored for its lane.
//   A last word then loads the output register.
//   Reset clears count, alignment and handshakes; width returns to 32.
//   A stalled receiver holds the count; words keep being taken until the
//   next last word, which waits for the output register to free up.
// ----------------------------------------------------------------------------
module bitpacked_equality_scan_count
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [31:0]                      packed_word,
    input  logic                             last_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [besc_pkg::COUNT_BITS-1:0]  match_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [31:0]                      cfg_data
);
    import besc_pkg::*;

    besc_cmd_t    cmd;
    besc_status_t status;

    besc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    besc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .packed_word (packed_word),
        .last_word   (last_word),
        .match_count (match_count)
    );

endmodule

// File: rtl/besc_checker.sv
// ----------------------------------------------------------------------------
// besc_checker
// Port-level checks on the equality scan handshakes.
// ----------------------------------------------------------------------------
`include "bitpacked_equality_scan_count_macros.svh"

module besc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_ready
);

    `BESC_ASSERT_NOW(a_cfg_in_ready, in_ready, cfg_ready, "input ready while config busy")
    `BESC_ASSERT_NEXT(a_busy_after_word, in_valid && in_ready, !in_ready, "ready after word")
    `BESC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")

endmodule

bind bitpacked_equality_scan_count besc_checker u_besc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_ready (cfg_ready)
);
